// File: rtl/decoded_frame_to_rgba_converter_macros.svh
// Assertion helpers shared by the converter RTL.
`ifndef DECODED_FRAME_TO_RGBA_CONVERTER_MACROS_SVH
`define DECODED_FRAME_TO_RGBA_CONVERTER_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define DFR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define DFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/dfr_pkg.sv
`default_nettype none
package dfr_pkg;
    localparam int unsigned FORMAT_W = 3;
    localparam logic [FORMAT_W-1:0] FMT_RGBA = 3'd0;
    localparam logic [FORMAT_W-1:0] FMT_ARGB = 3'd1;
    localparam logic [FORMAT_W-1:0] FMT_I420 = 3'd2;
    localparam logic [FORMAT_W-1:0] FMT_NV12 = 3'd3;
    localparam logic [FORMAT_W-1:0] FMT_GRAY = 3'd4;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_FORMAT = 2'd2;

    localparam int unsigned POS_W = 21;
    localparam int unsigned IDX_W = 19;

    typedef struct packed {
        logic [7:0]  src_byte;
        logic        frame_end;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0] pixel_index;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [7:0]       alpha;
        logic             run_last;
    } t_out_item;

    // Floor shift by 8 and clamp to 0..255 of a signed sum.
    function automatic logic [7:0] clamp_shift(input logic signed [19:0] x);
        logic signed [11:0] q;
        q = 12'(x >>> 8);
        if (q < 0) return 8'd0;
        else if (q > 12'sd255) return 8'd255;
        else return q[7:0];
    endfunction
endpackage
`default_nettype wire

// File: rtl/dfr_stream_if.sv
`default_nettype none
interface dfr_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/dfr_ram.sv
`default_nettype none
module dfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: rtl/decoded_frame_to_rgba_converter.sv
// Channel | Dir | Payload                                      | Handshake
// in      | in  | src_byte, frame_end                          | valid/ready
// out     | out | pixel_index, red, green, blue, alpha, run_last| valid/ready
// cfg     | in  | i_cfg_index, i_cfg_data                      | i_cfg_we
// One byte is accepted per cycle while no quad is being read and the output queue has room for four pixels.
// A Cr byte reads four luma entries from the luma memory, one per cycle, and
// no further byte is accepted until those reads are done; other bytes do not hold the input.
// Pixels leave through an 8-entry queue. Reset is synchronous and clears control only.
// The memories need no clearing pass.
`default_nettype none
`include "decoded_frame_to_rgba_converter_macros.svh"
module decoded_frame_to_rgba_converter #(
    parameter int MAX_WIDTH  = 640,
    parameter int MAX_HEIGHT = 480
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [9:0] i_cfg_data,
    dfr_stream_if.sink      in_if,
    dfr_stream_if.source    out_if
);
    import dfr_pkg::*;

    localparam int LDEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int CDEPTH = (MAX_WIDTH / 2) * (MAX_HEIGHT / 2);
    localparam int LA_W   = $clog2(LDEPTH);
    localparam int CA_W   = $clog2(CDEPTH);
    localparam int QDEPTH = 8;
    localparam int QA_W   = 3;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    // Configuration registers.
    logic [9:0] r_width;
    logic [8:0] r_height;
    logic [2:0] r_format;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 10'd640;
            r_height <= 9'd480;
            r_format <= FMT_RGBA;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_WIDTH:  r_width  <= i_cfg_data;
                REG_HEIGHT: r_height <= i_cfg_data[8:0];
                REG_FORMAT: r_format <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // Frame geometry from the next register values, so a write applies to the next byte.
    logic [9:0]       n_width, n_w;
    logic [8:0]       n_height, n_h;
    logic [POS_W-1:0] n_s, n_c;
    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        if (!i_rst_n) begin
            n_width  = 10'd640;
            n_height = 9'd480;
        end else if (i_cfg_we && i_cfg_index == REG_WIDTH) begin
            n_width = i_cfg_data;
        end else if (i_cfg_we && i_cfg_index == REG_HEIGHT) begin
            n_height = i_cfg_data[8:0];
        end
        n_w = (32'(n_width) > MAX_WIDTH) ? 10'(MAX_WIDTH) : n_width;
        n_h = (32'(n_height) > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : n_height;
        n_s = POS_W'(n_w) * POS_W'(n_h);
        n_c = POS_W'(n_w[9:1]) * POS_W'(n_h[8:1]);
    end

    logic [9:0]       r_w, r_hw;
    logic [8:0]       r_h;
    logic [POS_W-1:0] r_s, r_c, r_sc, r_s2c;
    always_ff @(posedge i_clk) begin
        r_w   <= n_w;
        r_h   <= n_h;
        r_hw  <= {1'b0, n_w[9:1]};
        r_s   <= n_s;
        r_c   <= n_c;
        r_sc  <= n_s + n_c;
        r_s2c <= n_s + n_c + n_c;
    end

    // Position, chroma coordinates and pending bytes.
    logic [POS_W-1:0] r_pos;
    logic [23:0]      r_pend;
    logic [7:0]       r_pcb;
    logic [8:0]       r_ci;          // chroma column in current row
    logic [LA_W-1:0]  r_rowbase;     // luma index of top-left of quad

    // Quad engine: four luma reads on consecutive cycles.
    logic             r_busy;
    logic [1:0]       r_sub;
    logic [LA_W-1:0]  r_qbase;
    logic [7:0]       r_qcb, r_qcr;

    // Queue.
    t_out_item        r_q [QDEPTH];
    logic [QA_W-1:0]  r_qwp, r_qrp;
    logic [QA_W:0]    r_qcnt;

    logic acc, emit_rgb, start_quad, chroma_cr, plane_i420_cb, luma_wr;
    logic [7:0] byte_v;
    logic [POS_W-1:0] o_off;
    assign byte_v = in_if.data.src_byte;
    assign o_off  = r_pos - r_s;

    // Room check counts items in flight down the quad pipe.
    logic [QA_W:0] r_inflight;
    assign in_if.ready = !r_busy && (r_qcnt + r_inflight <= (QA_W+1)'(QDEPTH - 4));
    assign acc = in_if.valid && in_if.ready;
    assign luma_wr = acc && (r_format == FMT_I420 || r_format == FMT_NV12) && (r_pos < r_s);
    assign plane_i420_cb = acc && r_format == FMT_I420 && r_pos >= r_s && r_pos < r_sc;
    assign chroma_cr = (r_format == FMT_I420) ? (r_pos >= r_sc && r_pos < r_s2c)
                     : (r_format == FMT_NV12) ? (r_pos >= r_s && r_pos < r_s2c && o_off[0])
                     : 1'b0;
    assign start_quad = acc && chroma_cr;
    assign emit_rgb = acc && !(r_format == FMT_I420 || r_format == FMT_NV12)
                      && r_pos[1:0] == 2'b11 && (r_pos >> 2) < r_s;

    // The Cb entry of the sample is read while its Cr byte is accepted.
    logic [CA_W-1:0] cb_raddr_next;
    assign cb_raddr_next = CA_W'(r_pos - r_sc);

    // Luma memory.
    logic [LA_W-1:0] l_raddr;
    logic [7:0]      l_rd;
    assign l_raddr = r_qbase + ((r_sub[1]) ? LA_W'(r_w) : '0) + LA_W'(r_sub[0]);
    dfr_ram #(.WIDTH(8), .DEPTH(LDEPTH)) u_luma (
        .i_clk, .i_we(luma_wr), .i_waddr(LA_W'(r_pos)), .i_wdata(byte_v),
        .i_raddr(l_raddr), .o_rdata(l_rd));

    // Cb memory for I420 quads.
    logic [7:0] cb_q_rd;
    dfr_ram #(.WIDTH(8), .DEPTH(CDEPTH)) u_cb2 (
        .i_clk, .i_we(plane_i420_cb), .i_waddr(CA_W'(r_pos - r_s)), .i_wdata(byte_v),
        .i_raddr(cb_raddr_next), .o_rdata(cb_q_rd));

    // Stage 1 registers (luma data arrives); stage 2 registers the luma product; the clamp is combinational.
    logic             r_s1_v, r_s1_last;
    logic [LA_W-1:0]  r_s1_idx;
    logic signed [18:0] r_yc;
    logic             r_s2_v, r_s2_last;
    logic [LA_W-1:0]  r_s2_idx;
    logic signed [9:0] d_v, e_v, r_d, r_e;

    assign d_v = $signed({2'b0, r_qcb}) - 10'sd128;
    assign e_v = $signed({2'b0, r_qcr}) - 10'sd128;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0; r_pend <= '0; r_pcb <= '0;
            r_busy <= 1'b0; r_sub <= '0;
            r_s1_v <= 1'b0; r_s2_v <= 1'b0;
            r_ci <= '0; r_rowbase <= '0;
        end else begin
            if (acc) begin
                if (in_if.data.frame_end) r_pos <= '0;
                else if (r_pos != POS_MAX) r_pos <= r_pos + 1'b1;
                if (!(r_format == FMT_I420 || r_format == FMT_NV12) && r_pos[1:0] != 2'b11)
                    r_pend[8*r_pos[1:0] +: 8] <= byte_v;
                if (r_format == FMT_NV12 && r_pos >= r_s && r_pos < r_s2c && !o_off[0])
                    r_pcb <= byte_v;
            end
            if (start_quad) begin
                r_busy  <= 1'b1;
                r_sub   <= '0;
                r_qcr   <= byte_v;
                r_qcb   <= r_pcb;
                r_qbase <= r_rowbase;
                // Advance chroma coordinates.
                if ({1'b0, r_ci} + 10'd1 >= r_hw) begin
                    r_ci <= '0;
                    r_rowbase <= r_rowbase + LA_W'(r_w) + LA_W'(r_w) - LA_W'({r_ci, 1'b0});
                end else begin
                    r_ci <= r_ci + 1'b1;
                    r_rowbase <= r_rowbase + LA_W'(2);
                end
            end else if (r_busy) begin
                // The I420 Cb entry read from memory arrives in the cycle after its Cr byte is accepted.
                if (r_sub == 2'd0 && r_format == FMT_I420) r_qcb <= cb_q_rd;
                r_sub <= r_sub + 1'b1;
                if (r_sub == 2'd3) r_busy <= 1'b0;
            end
            // Reset chroma coordinates at the start of a chroma plane or a frame.
            if (acc && !start_quad && (r_pos == r_s || in_if.data.frame_end
                    || (r_format == FMT_I420 && r_pos == r_sc - 1'b1))) begin
                r_ci <= '0; r_rowbase <= '0;
            end
            r_s1_v    <= r_busy;
            r_s1_last <= r_sub == 2'd3;
            r_s1_idx  <= l_raddr;
            r_s2_v    <= r_s1_v;
            r_s2_last <= r_s1_last;
            r_s2_idx  <= r_s1_idx;
        end
        if (r_s1_v) begin
            r_yc <= 19'(298 * ($signed({2'b0, l_rd}) - 10'sd16));
            r_d  <= d_v;
            r_e  <= e_v;
        end
    end

    // Final math and queue write.
    logic signed [19:0] sr, sg, sb;
    assign sr = 20'(r_yc) + 20'(409 * r_e) + 20'sd128;
    assign sg = 20'(r_yc) - 20'(100 * r_d) - 20'(208 * r_e) + 20'sd128;
    assign sb = 20'(r_yc) + 20'(516 * r_d) + 20'sd128;

    t_out_item w_item;
    logic      w_v;
    always_comb begin
        w_v = 1'b0;
        w_item = '0;
        if (r_s2_v) begin
            w_v = 1'b1;
            w_item.pixel_index = IDX_W'(r_s2_idx);
            w_item.red   = clamp_shift(sr);
            w_item.green = clamp_shift(sg);
            w_item.blue  = clamp_shift(sb);
            w_item.alpha = 8'd255;
            w_item.run_last = r_s2_last;
        end else if (emit_rgb) begin
            w_v = 1'b1;
            w_item.pixel_index = IDX_W'(r_pos >> 2);
            w_item.run_last = 1'b1;
            priority if (r_format == FMT_RGBA) begin
                w_item.red = r_pend[7:0]; w_item.green = r_pend[15:8];
                w_item.blue = r_pend[23:16]; w_item.alpha = byte_v;
            end else if (r_format == FMT_ARGB) begin
                w_item.red = r_pend[15:8]; w_item.green = r_pend[23:16];
                w_item.blue = byte_v; w_item.alpha = 8'd255;
            end else begin
                w_item.red = 8'd90; w_item.green = 8'd90;
                w_item.blue = 8'd90; w_item.alpha = 8'd90;
            end
        end
    end

    logic pop;
    assign pop = out_if.valid && out_if.ready;
    assign out_if.valid = r_qcnt != '0;
    assign out_if.data  = r_q[r_qrp];

    always_ff @(posedge i_clk) begin
        if (w_v) r_q[r_qwp] <= w_item;
        if (!i_rst_n) begin
            r_qwp <= '0; r_qrp <= '0; r_qcnt <= '0; r_inflight <= '0;
        end else begin
            if (w_v) r_qwp <= r_qwp + 1'b1;
            if (pop) r_qrp <= r_qrp + 1'b1;
            r_qcnt <= r_qcnt + (QA_W+1)'(w_v) - (QA_W+1)'(pop);
            r_inflight <= r_inflight + (start_quad ? (QA_W+1)'(4) : '0)
                          - (QA_W+1)'(r_s2_v);
        end
    end

    `DFR_ASSERT_IMP(a_qcap, i_clk, i_rst_n, 1'b1, r_qcnt <= (QA_W+1)'(QDEPTH), "queue overflow")
    `DFR_ASSERT_NEXT(a_quad, i_clk, i_rst_n, start_quad, r_busy, "quad did not start")
    `DFR_ASSERT_IMP(a_noacc, i_clk, i_rst_n, r_busy, !in_if.ready, "input taken during quad")
endmodule
`default_nettype wire

// File: sim/tb_top.sv
`default_nettype none
module tb_top;
    import dfr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXW = 640;
    localparam int MAXH = 480;
    localparam int WATCHDOG_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [9:0] i_cfg_data;

    dfr_stream_if #(.T(t_in_item)) in_ch ();
    dfr_stream_if #(.T(t_out_item)) out_ch ();

    decoded_frame_to_rgba_converter #(.MAX_WIDTH(MAXW), .MAX_HEIGHT(MAXH)) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .in_if(in_ch.sink),
        .out_if(out_ch.source)
    );

    // Predictor state, a copy of what the block holds.
    logic [9:0] cur_width;
    logic [8:0] cur_height;
    logic [2:0] cur_format;
    logic [20:0] byte_pos;
    logic [23:0] held_bytes;
    logic [7:0] held_cb;
    logic [7:0] luma_mem [MAXW*MAXH];
    logic [7:0] cb_mem [(MAXW/2)*(MAXH/2)];

    t_out_item pixel_queue[$];
    int unsigned mismatch_count;
    int unsigned idle_cycles;
    int send_idle_pct;
    int recv_stall_pct;
    bit recv_hold;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [7:0] sat_shift(input int x);
        int q;
        q = ((x + 65536) >>> 8) - 256;
        if (q < 0) return 8'd0;
        if (q > 255) return 8'd255;
        return q[7:0];
    endfunction

    // Push the four pixels of one chroma sample in raster order.
    function automatic void predict_quad(input int k, input int w, input int hw,
                                         input logic [7:0] cb, input logic [7:0] cr);
        int cj, ci, idx, c, d, e;
        t_out_item px;
        cj = k / hw;
        ci = k % hw;
        d = int'(cb) - 128;
        e = int'(cr) - 128;
        for (int dy = 0; dy < 2; dy++) begin
            for (int dx = 0; dx < 2; dx++) begin
                idx = (2*cj + dy) * w + 2*ci + dx;
                c = int'(luma_mem[idx]) - 16;
                px.pixel_index = idx[IDX_W-1:0];
                px.red = sat_shift(298*c + 409*e + 128);
                px.green = sat_shift(298*c - 100*d - 208*e + 128);
                px.blue = sat_shift(298*c + 516*d + 128);
                px.alpha = 8'd255;
                px.run_last = (dy == 1 && dx == 1);
                pixel_queue.push_back(px);
            end
        end
    endfunction

    // Work out the pixels that one accepted byte causes.
    function automatic void predict_byte(input t_in_item it);
        int w, h, s, hw, cc, p, slot, pix;
        t_out_item px;
        w = (cur_width > MAXW) ? MAXW : int'(cur_width);
        h = (cur_height > MAXH) ? MAXH : int'(cur_height);
        s = w * h;
        hw = w / 2;
        cc = hw * (h / 2);
        p = int'(byte_pos);
        if (cur_format == FMT_I420) begin
            if (p < s) luma_mem[p] = it.src_byte;
            else if (p < s + cc) cb_mem[p - s] = it.src_byte;
            else if (p < s + 2*cc) predict_quad(p - s - cc, w, hw, cb_mem[p - s - cc],
                                                it.src_byte);
        end else if (cur_format == FMT_NV12) begin
            if (p < s) luma_mem[p] = it.src_byte;
            else if (p < s + 2*cc) begin
                if (((p - s) & 1) == 0) held_cb = it.src_byte;
                else predict_quad((p - s) >> 1, w, hw, held_cb, it.src_byte);
            end
        end else begin
            slot = p & 3;
            pix = p >> 2;
            if (slot < 3) held_bytes[8*slot +: 8] = it.src_byte;
            else if (pix < s) begin
                px.pixel_index = pix[IDX_W-1:0];
                if (cur_format == FMT_RGBA) begin
                    {px.blue, px.green, px.red} = held_bytes;
                    px.alpha = it.src_byte;
                end else if (cur_format == FMT_ARGB) begin
                    px.red = held_bytes[15:8];
                    px.green = held_bytes[23:16];
                    px.blue = it.src_byte;
                    px.alpha = 8'd255;
                end else begin
                    px.red = 8'd90; px.green = 8'd90; px.blue = 8'd90; px.alpha = 8'd90;
                end
                px.run_last = 1'b1;
                pixel_queue.push_back(px);
            end
        end
        if (it.frame_end) byte_pos = '0;
        else if (byte_pos != '1) byte_pos++;
    endfunction

    // Compare each accepted pixel with the oldest prediction.
    always @(posedge i_clk) begin
        t_out_item want, got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            if (pixel_queue.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected pixel: %p", got);
            end else begin
                want = pixel_queue.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("pixel mismatch: expected %p, actual %p", want, got);
                end
            end
        end
    end

    // Receiver readiness, with random stalls and an optional long hold.
    always @(negedge i_clk) begin
        if (recv_hold) out_ch.ready <= 1'b0;
        else out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog over cycles with no handshake on either side.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Offer one item; valid stays high on return so items can follow back to back.
    task automatic send_byte(input logic [7:0] b, input logic fe);
        t_in_item it;
        it.src_byte = b;
        it.frame_end = fe;
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_byte(it);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pixel_queue.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        if (idx == REG_WIDTH) cur_width = val;
        else if (idx == REG_HEIGHT) cur_height = val[8:0];
        else cur_format = val[2:0];
    endtask

    task automatic set_frame(input int w, input int h, input int fmt);
        wait_drained();
        write_reg(REG_WIDTH, w[9:0]);
        write_reg(REG_HEIGHT, h[9:0]);
        write_reg(REG_FORMAT, fmt[9:0]);
        i_cfg_we <= 1'b0;
    endtask

    // Sends nbytes + extra bytes, frame_end on the last; YUV frames carry their luma plane first.
    task automatic send_frame(input int nbytes, input int extra, input int mode);
        logic [7:0] b;
        for (int i = 0; i < nbytes + extra; i++) begin
            case (mode)
                0: b = 8'($urandom_range(255));
                1: b = (i % 2) ? 8'hff : 8'h00;
                default: b = (i % 3 == 0) ? 8'hff : ((i % 3 == 1) ? 8'h00 : 8'h80);
            endcase
            send_byte(b, i == nbytes + extra - 1);
        end
    endtask

    function automatic int frame_bytes(input int w, input int h, input int fmt);
        if (fmt == FMT_I420 || fmt == FMT_NV12) return w*h + 2*((w/2)*(h/2));
        return 4*w*h;
    endfunction

    task automatic test_directed();
        // Passthrough formats with extreme and mid-scale bytes, gray for unknown formats.
        set_frame(2, 2, FMT_RGBA);
        send_frame(16, 0, 1);
        set_frame(2, 2, FMT_ARGB);
        send_frame(16, 0, 2);
        set_frame(2, 2, FMT_GRAY);
        send_frame(16, 0, 0);
        // YUV saturation both ways, and bytes past the layout.
        set_frame(2, 2, FMT_I420);
        send_frame(6, 2, 1);
        set_frame(2, 2, FMT_NV12);
        send_frame(6, 0, 2);
    endtask

    task automatic test_random(input int budget);
        int w, h, fmt, sent;
        sent = 0;
        while (sent < budget) begin
            fmt = $urandom_range(7);
            w = 2 * $urandom_range(1, 3);
            h = 2 * $urandom_range(1, 2);
            if ($urandom_range(9) == 0) begin
                // Odd size: in YUV formats the trailing column or row is never emitted.
                w = w + 1;
                h = h + ($urandom_range(1));
            end
            set_frame(w, h, fmt);
            send_frame(frame_bytes(w, h, fmt), $urandom_range(2), 0);
            sent += frame_bytes(w, h, fmt);
        end
    endtask

    task automatic test_oversize();
        // Saturated width, tiny height, the first four pixels in ARGB; then saturated height in RGBA.
        set_frame(1023, 2, FMT_ARGB);
        send_frame(16, 0, 0);
        set_frame(640, 511, FMT_RGBA);
        send_frame(8, 0, 0);
    endtask

    task automatic test_backpressure();
        set_frame(4, 4, FMT_NV12);
        fork
            begin
                recv_hold = 1'b1;
                repeat (200) @(negedge i_clk);
                recv_hold = 1'b0;
            end
            send_frame(frame_bytes(4, 4, FMT_NV12), 0, 0);
        join
    endtask

    initial begin
        mismatch_count = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        recv_hold = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_WIDTH;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        cur_width = 10'd640;
        cur_height = 9'd480;
        cur_format = FMT_RGBA;
        byte_pos = '0;
        held_bytes = '0;
        held_cb = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_oversize();
        test_random(1);
        send_idle_pct = 75;
        test_random(1);
        send_idle_pct = 0;
        recv_stall_pct = 75;
        test_random(1);
        send_idle_pct = 8;
        recv_stall_pct = 8;
        test_random(1);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_backpressure();
        wait_drained();

        if (mismatch_count == 0 && pixel_queue.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
